// ----- hw/rtl/sbpd_pkg.sv -----
// Shared types and constants for the start-byte packet deframer.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package sbpd_pkg;

  // Frame layout: payload bytes, then a little-endian correction bitmap.
  localparam int unsigned FrameBytes = 14;
  localparam int unsigned BitmapPos  = 12;
  localparam int unsigned CountW     = 4;

  localparam logic [7:0] StartValue = 8'hFF;
  localparam logic [CountW-1:0] BitmapLoIdx = CountW'(BitmapPos);
  localparam logic [CountW-1:0] BitmapHiIdx = CountW'(BitmapPos + 1);
  localparam logic [CountW-1:0] FrameLastIdx = CountW'(FrameBytes - 1);

  // Input event kinds carried on tuser.
  localparam logic OpByte    = 1'b0;
  localparam logic OpLineErr = 1'b1;

  typedef enum logic [2:0] {
    StHunt,
    StCollect,
    StEmit,
    StFailed
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic byte_wr;    // store the accepted byte at the frame count, then count up
    logic frame_clr;  // clear the frame count and the emit index
    logic emit_load;  // load the next corrected payload byte into the output register
    logic err_load;   // load an error result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_valid;   // output register holds a beat
    logic start_seen;  // input byte equals the start value
    logic frame_last;  // the next stored byte completes the frame
    logic emit_last;   // the next emitted byte is the final payload byte
  } sts_t;

endpackage

// ----- hw/rtl/sbpd_ctrl.sv -----
// Controller state machine of the start-byte packet deframer.
// Depends on sbpd_pkg; drives commands to sbpd_datapath.
`timescale 1ns / 1ps

module sbpd_ctrl
  import sbpd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_opcode_i,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   slot_free;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StHunt;
    end else begin
      state_q <= state_d;
    end
  end

  // The output register may be reloaded when empty or when its beat leaves now.
  assign slot_free = !sts_i.out_valid || out_ready_i;
  // Only read while hunting or collecting, where ready follows the free slot.
  assign accept    = in_valid_i && slot_free;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      StHunt: begin
        in_ready_o = slot_free;
        if (accept) begin
          if (in_opcode_i == OpLineErr) begin
            cmd_o.err_load = 1'b1;
            state_d        = StFailed;
          end else if (sts_i.start_seen) begin
            cmd_o.frame_clr = 1'b1;
            state_d         = StCollect;
          end
        end
      end
      StCollect: begin
        in_ready_o = slot_free;
        if (accept) begin
          if (in_opcode_i == OpLineErr) begin
            cmd_o.err_load  = 1'b1;
            cmd_o.frame_clr = 1'b1;
            state_d         = StFailed;
          end else begin
            cmd_o.byte_wr = 1'b1;
            if (sts_i.frame_last) begin
              cmd_o.frame_clr = 1'b1;
              state_d         = StEmit;
            end
          end
        end
      end
      StEmit: begin
        if (slot_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.emit_last) begin
            state_d = StHunt;
          end
        end
      end
      StFailed: begin
        // Sticky until reset: every beat is taken and dropped.
        in_ready_o = 1'b1;
      end
      default: begin
        state_d = StFailed;
      end
    endcase
  end

  a_failed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFailed |-> !cmd_o.emit_load && !cmd_o.err_load)
    else $error("result produced in failed state");

  a_error_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.err_load |=> state_q == StFailed)
    else $error("line error did not latch the failed state");

  a_no_input_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> !in_ready_o && !cmd_o.byte_wr)
    else $error("input taken while emitting a packet");

endmodule

// ----- hw/rtl/sbpd_datapath.sv -----
// Datapath of the start-byte packet deframer: frame store, bitmap, counters
// and the output register. Depends on sbpd_pkg; commanded by sbpd_ctrl.
`timescale 1ns / 1ps

module sbpd_datapath
  import sbpd_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_ready_i,
  output sts_t       sts_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       out_err_o,
  output logic       out_valid_o
);

  localparam int unsigned IdxW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PAYLOAD_BYTES - 1);
  localparam logic [CountW-1:0] PayloadCount = CountW'(PAYLOAD_BYTES);

  logic [7:0]               store_q [PAYLOAD_BYTES];
  logic [PAYLOAD_BYTES-1:0] corr_q;
  logic [7:0]               bitmap_lo_q;
  logic [15:0]              bitmap_full;
  logic [CountW-1:0]        count_q;
  logic [IdxW-1:0]          idx_q;
  logic                     out_valid_q;
  logic [7:0]               out_byte_q;
  logic                     out_last_q;
  logic                     out_err_q;

  assign bitmap_full = {in_byte_i, bitmap_lo_q};

  // Frame bytes beyond the payload width are never emitted, so only the
  // payload bytes and the two bitmap bytes are kept.
  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_wr) begin
      if (count_q < PayloadCount) begin
        store_q[count_q[IdxW-1:0]] <= in_byte_i;
      end
      if (count_q == BitmapLoIdx) begin
        bitmap_lo_q <= in_byte_i;
      end
      if (count_q == BitmapHiIdx) begin
        corr_q <= bitmap_full[PAYLOAD_BYTES-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else if (cmd_i.frame_clr) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.byte_wr) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.emit_load) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load || cmd_i.err_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.err_load) begin
      out_byte_q <= '0;
      out_last_q <= 1'b0;
      out_err_q  <= 1'b1;
    end else if (cmd_i.emit_load) begin
      out_byte_q <= corr_q[idx_q] ? StartValue : store_q[idx_q];
      out_last_q <= (idx_q == LastIdx);
      out_err_q  <= 1'b0;
    end
  end

  assign sts_o.out_valid  = out_valid_q;
  assign sts_o.start_seen = (in_byte_i == StartValue);
  assign sts_o.frame_last = (count_q == FrameLastIdx);
  assign sts_o.emit_last  = (idx_q == LastIdx);

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_err_o   = out_err_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_load || cmd_i.err_load) |-> !out_valid_q || out_ready_i)
    else $error("output register overwritten while its beat is pending");

  a_count_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.byte_wr |-> count_q <= FrameLastIdx)
    else $error("frame byte written beyond the frame length");

  a_last_not_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> !out_last_q && out_byte_q == '0)
    else $error("error result carries payload fields");

endmodule

// ----- hw/rtl/start_byte_packet_deframer.sv -----
// Top level of the start-byte packet deframer.
// Depends on sbpd_pkg, sbpd_ctrl and sbpd_datapath.
//
//   channel   direction  tdata               tuser             tlast
//   s_axis    in         rx_byte[7:0]        opcode (1 = error) -
//   m_axis    out        payload_byte[7:0]   error_flag        last_byte
//
// A byte beat is taken every cycle while hunting for the start value or
// collecting the 14-byte frame, unless a pending output beat is stalled. Once
// the frame is complete, input is held off while the corrected payload leaves
// one beat per cycle from the output register while the receiver is ready.
// Reset clears the controller, counters and output valid; the frame store
// needs no clearing. After a line error all input beats are taken and dropped.
`timescale 1ns / 1ps

module start_byte_packet_deframer
  import sbpd_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic       s_axis_tuser,   // [0] opcode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic       m_axis_tuser,   // [0] error_flag
  output logic       m_axis_tlast
);

  cmd_t cmd;
  sts_t sts;

  sbpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd)
  );

  sbpd_datapath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_byte_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .sts_o       (sts),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser),
    .out_valid_o (m_axis_tvalid)
  );

endmodule

// ----- sim/start_byte_packet_deframer_test.sv -----
// Self-checking testbench for the start-byte packet deframer: directed frames from a table,
// then random framed traffic under varying stream gaps, checked against a behavioural deframer.
// Depends on sbpd_pkg and start_byte_packet_deframer.
`timescale 1ns / 1ps

module start_byte_packet_deframer_test;
  import sbpd_pkg::*;

  localparam int unsigned PayloadBytes = 12;
  localparam int unsigned RandomItems  = 420;
  localparam int unsigned HoldCycles   = 150;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned RunLimitNs   = 2_000_000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } beat_t;

  typedef enum logic [1:0] {
    ExpPredict,
    ExpNone,
    ExpOne
  } exp_kind_e;

  typedef enum logic [1:0] {
    GapNone,
    GapSender,
    GapReceiver,
    GapBoth
  } gap_mode_e;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    exp_kind_e  kind;
    beat_t      beat;
  } stim_row_t;

  // Opening traffic: junk while hunting, then one frame that carries the start value as
  // payload, a bitmap touching a byte that is already 0xFF, and the unused bitmap bits set.
  localparam stim_row_t DirectedRows [21] = '{
    '{OpByte, 8'h00, ExpNone, '0},
    '{OpByte, 8'hFE, ExpNone, '0},
    '{OpByte, 8'h7F, ExpNone, '0},
    '{OpByte, 8'h80, ExpNone, '0},
    '{OpByte, 8'hFF, ExpNone, '0},
    '{OpByte, 8'hFF, ExpPredict, '0},
    '{OpByte, 8'h00, ExpPredict, '0},
    '{OpByte, 8'h01, ExpPredict, '0},
    '{OpByte, 8'h80, ExpPredict, '0},
    '{OpByte, 8'h7F, ExpPredict, '0},
    '{OpByte, 8'hFE, ExpPredict, '0},
    '{OpByte, 8'h55, ExpPredict, '0},
    '{OpByte, 8'hAA, ExpPredict, '0},
    '{OpByte, 8'h0F, ExpPredict, '0},
    '{OpByte, 8'hF0, ExpPredict, '0},
    '{OpByte, 8'h3C, ExpPredict, '0},
    '{OpByte, 8'hC3, ExpPredict, '0},
    '{OpByte, 8'h21, ExpPredict, '0},
    '{OpByte, 8'hF8, ExpPredict, '0},
    '{OpByte, 8'h00, ExpNone, '0},
    '{OpByte, 8'h12, ExpNone, '0}
  };

  // Closing traffic: a line error in the middle of a frame, then beats that must be dropped.
  localparam stim_row_t ClosingRows [9] = '{
    '{OpByte, 8'hFF, ExpNone, '0},
    '{OpByte, 8'h11, ExpPredict, '0},
    '{OpByte, 8'h22, ExpPredict, '0},
    '{OpByte, 8'h33, ExpPredict, '0},
    '{OpLineErr, 8'hA5, ExpOne, '{8'h00, 1'b0, 1'b1}},
    '{OpByte, 8'hFF, ExpNone, '0},
    '{OpByte, 8'h44, ExpNone, '0},
    '{OpLineErr, 8'h00, ExpNone, '0},
    '{OpByte, 8'h00, ExpNone, '0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       s_valid;
  logic [7:0] s_data;
  logic       s_user;
  logic       m_ready;
  logic       s_axis_tready;
  logic       m_axis_tvalid;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  // Behavioural copy of the deframer state.
  logic       in_frame;
  logic [3:0] frame_cnt;
  logic [7:0] frame_buf [FrameBytes];
  logic       line_failed;

  beat_t      fresh_beats [$];
  beat_t      expected_beats [$];
  int         mismatches;
  int         stall_left;
  gap_mode_e  gap_mode;

  start_byte_packet_deframer #(
    .PAYLOAD_BYTES(PayloadBytes)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(RunLimitNs);
    $display("** start_byte_packet_deframer: FAILED **");
    $finish;
  end

  // Works out the beats that one accepted input beat releases; they land in fresh_beats.
  function automatic void deframe_predict(input logic op, input logic [7:0] rx);
    logic [15:0] fix_mask;
    logic [7:0]  value;
    fresh_beats.delete();
    if (line_failed) return;
    if (op == OpLineErr) begin
      line_failed = 1'b1;
      in_frame    = 1'b0;
      frame_cnt   = '0;
      fresh_beats.push_back('{8'h00, 1'b0, 1'b1});
      return;
    end
    if (!in_frame) begin
      if (rx == StartValue) begin
        in_frame  = 1'b1;
        frame_cnt = '0;
      end
      return;
    end
    frame_buf[frame_cnt] = rx;
    frame_cnt = frame_cnt + 4'd1;
    if (frame_cnt < FrameBytes) return;
    fix_mask = {frame_buf[BitmapPos + 1], frame_buf[BitmapPos]};
    for (int i = 0; i < PayloadBytes; i++) begin
      value = fix_mask[i] ? StartValue : frame_buf[i];
      fresh_beats.push_back('{value, (i == PayloadBytes - 1), 1'b0});
    end
    in_frame  = 1'b0;
    frame_cnt = '0;
  endfunction

  // Entered and left at a falling edge; offers one beat and waits for it to be taken.
  task automatic offer_beat(input logic op, input logic [7:0] rx, input exp_kind_e kind,
                            input beat_t typed_beat);
    int idle_pct;
    idle_pct = (gap_mode == GapSender) ? 47 : (gap_mode == GapBoth) ? 7 : 0;
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= rx;
    s_user  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    deframe_predict(op, rx);
    case (kind)
      ExpPredict: foreach (fresh_beats[i]) expected_beats.push_back(fresh_beats[i]);
      ExpOne:     expected_beats.push_back(typed_beat);
      default:    ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic flag_mismatch(input bit unexpected, input beat_t want, input beat_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      if (unexpected)
        $display("%0t: unexpected beat data=%02h last=%b err=%b", $realtime,
                 got.data, got.last, got.err);
      else
        $display({"%0t: beat mismatch: expected data=%02h last=%b err=%b, ",
                  "got data=%02h last=%b err=%b"},
                 $realtime, want.data, want.last, want.err, got.data, got.last, got.err);
    end
  endtask

  // Receiver side: ready changes at the falling edge; a long hold-off takes priority.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (gap_mode == GapReceiver) begin
      m_ready <= ($urandom_range(99) >= 47);
    end else if (gap_mode == GapBoth) begin
      m_ready <= ($urandom_range(99) >= 7);
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    beat_t got;
    beat_t want;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
      if (expected_beats.size() == 0) begin
        flag_mismatch(1'b1, '0, got);
      end else begin
        want = expected_beats.pop_front();
        if (got.data !== want.data || got.last !== want.last || got.err !== want.err)
          flag_mismatch(1'b0, want, got);
      end
    end
  end

  initial begin
    int          counted;
    int          frame_no;
    int          noise;
    bit          dense;
    logic [15:0] fix_bits;
    logic [7:0]  pay;

    rst_ni      = 1'b0;
    s_valid     = 1'b0;
    s_data      = 8'h00;
    s_user      = OpByte;
    m_ready     = 1'b0;
    stall_left  = 0;
    gap_mode    = GapNone;
    mismatches  = 0;
    in_frame    = 1'b0;
    frame_cnt   = '0;
    line_failed = 1'b0;
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[r])
      offer_beat(DirectedRows[r].op, DirectedRows[r].data, DirectedRows[r].kind,
                 DirectedRows[r].beat);

    // Well-formed frames with random content, separated by stray bytes.
    counted  = 0;
    frame_no = 0;
    while (counted < RandomItems) begin
      gap_mode = gap_mode_e'((frame_no / 3) % 4);
      noise = $urandom_range(0, 2);
      repeat (noise) offer_beat(OpByte, 8'($urandom_range(0, 254)), ExpPredict, '0);
      offer_beat(OpByte, StartValue, ExpPredict, '0);
      counted++;
      // The receiver holds off for a long stretch while the sender keeps offering.
      if (frame_no == 12) stall_left = HoldCycles;
      case ($urandom_range(3))
        0:       fix_bits = 16'h0000;
        1:       fix_bits = 16'hFFFF;
        default: fix_bits = 16'($urandom_range(0, 65535));
      endcase
      dense = ($urandom_range(3) == 0);
      for (int k = 0; k < PayloadBytes; k++) begin
        pay = (dense && $urandom_range(1)) ? StartValue : 8'($urandom_range(0, 255));
        offer_beat(OpByte, pay, ExpPredict, '0);
        counted++;
      end
      offer_beat(OpByte, fix_bits[7:0], ExpPredict, '0);
      offer_beat(OpByte, fix_bits[15:8], ExpPredict, '0);
      counted += 2;
      frame_no++;
    end

    gap_mode = GapBoth;
    foreach (ClosingRows[r])
      offer_beat(ClosingRows[r].op, ClosingRows[r].data, ClosingRows[r].kind,
                 ClosingRows[r].beat);
    s_valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (PayloadBytes + 8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("** start_byte_packet_deframer: PASSED **");
    end else begin
      $display("** start_byte_packet_deframer: FAILED **");
    end
    $finish;
  end

endmodule
